### rtl/dqec_pkg.sv
// ----------------------------------------------------------------------------
// dqec_pkg
// Shared types, operation codes and the x4 quadrature table.
// ----------------------------------------------------------------------------
package dqec_pkg;

  localparam int unsigned CounterBits = 16;
  localparam int unsigned TotalBits   = 64;
  localparam int unsigned DeltaBits   = 32;

  typedef enum logic [2:0] {
    OpPinSample   = 3'd0,
    OpCounterPoll = 3'd1,
    OpReadDelta   = 3'd2,
    OpReadTotal   = 3'd3,
    OpResetChan   = 3'd4
  } op_e;

  localparam logic ChCounter = 1'b0;
  localparam logic ChPin     = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic        channel;
    logic        pin_a;
    logic        pin_b;
    logic [15:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic signed [TotalBits-1:0] total_count;
    logic signed [DeltaBits-1:0] delta_count;
  } out_item_t;

  // indexed by {prev_a, prev_b, cur_a, cur_b}
  localparam logic signed [1:0] QuadTable [16] = '{
    2'b00, 2'b01, 2'b11, 2'b00,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b00, 2'b11, 2'b01, 2'b00
  };

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

### rtl/dqec_in_stage.sv
// ----------------------------------------------------------------------------
// dqec_in_stage
// Input register; holds one transaction until the update stage takes it.
// ----------------------------------------------------------------------------
module dqec_in_stage
  import dqec_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     advance_i,
  output stage_t   stage_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

### rtl/dqec_update.sv
// ----------------------------------------------------------------------------
// dqec_update
// Channel state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module dqec_update
  import dqec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stage_t    stage_i,
  input  logic      slot_free_i,
  output logic      advance_o,
  output out_item_t result_o
);

  logic [CounterBits-1:0] last_counter_q, last_counter_d;
  logic [TotalBits-1:0]   counter_total_q, counter_total_d;
  logic [TotalBits-1:0]   counter_rep_q, counter_rep_d;
  logic [1:0]             last_pin_q, last_pin_d;
  logic [TotalBits-1:0]   pin_total_q, pin_total_d;
  logic [TotalBits-1:0]   pin_rep_q, pin_rep_d;

  in_item_t               item;
  logic [1:0]             pins;
  logic [CounterBits-1:0] cnt;
  logic [CounterBits-1:0] cnt_step;
  logic signed [1:0]      quad;
  logic [TotalBits-1:0]   cnt_sum;
  logic [TotalBits-1:0]   pin_sum;
  logic [TotalBits-1:0]   sel_total;
  logic [TotalBits-1:0]   sel_rep;
  logic [DeltaBits-1:0]   sel_delta;

  assign item      = stage_i.item;
  assign advance_o = stage_i.valid && slot_free_i;

  assign pins     = {item.pin_a, item.pin_b};
  assign cnt      = item.counter_value[CounterBits-1:0];
  assign cnt_step = cnt - last_counter_q;
  assign quad     = QuadTable[{last_pin_q, pins}];
  assign cnt_sum  = counter_total_q
                  + {{(TotalBits-CounterBits){cnt_step[CounterBits-1]}}, cnt_step};
  assign pin_sum  = pin_total_q + {{(TotalBits-2){quad[1]}}, quad};

  assign sel_total = (item.channel == ChPin) ? pin_total_q : counter_total_q;
  assign sel_rep   = (item.channel == ChPin) ? pin_rep_q : counter_rep_q;
  assign sel_delta = sel_total[DeltaBits-1:0] - sel_rep[DeltaBits-1:0];

  always_comb begin
    last_counter_d       = last_counter_q;
    counter_total_d      = counter_total_q;
    counter_rep_d        = counter_rep_q;
    last_pin_d           = last_pin_q;
    pin_total_d          = pin_total_q;
    pin_rep_d            = pin_rep_q;
    result_o.total_count = sel_total;
    result_o.delta_count = '0;
    case (op_e'(item.operation))
      OpPinSample: begin
        pin_total_d          = pin_sum;
        last_pin_d           = pins;
        result_o.total_count = pin_sum;
      end
      OpCounterPoll: begin
        counter_total_d      = cnt_sum;
        last_counter_d       = cnt;
        result_o.total_count = cnt_sum;
      end
      OpReadDelta: begin
        result_o.delta_count = sel_delta;
        if (item.channel == ChPin) begin
          pin_rep_d = pin_total_q;
        end else begin
          counter_rep_d = counter_total_q;
        end
      end
      OpResetChan: begin
        result_o.total_count = '0;
        if (item.channel == ChPin) begin
          last_pin_d  = pins;
          pin_total_d = '0;
          pin_rep_d   = '0;
        end else begin
          last_counter_d  = cnt;
          counter_total_d = '0;
          counter_rep_d   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_counter_q  <= '0;
      counter_total_q <= '0;
      counter_rep_q   <= '0;
      last_pin_q      <= '0;
      pin_total_q     <= '0;
      pin_rep_q       <= '0;
    end else if (advance_o) begin
      last_counter_q  <= last_counter_d;
      counter_total_q <= counter_total_d;
      counter_rep_q   <= counter_rep_d;
      last_pin_q      <= last_pin_d;
      pin_total_q     <= pin_total_d;
      pin_rep_q       <= pin_rep_d;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |=> $stable(counter_total_q) && $stable(pin_total_q)
                   && $stable(counter_rep_q) && $stable(pin_rep_q))
    else $error("channel state changed without a transaction");

  a_reset_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && item.operation == OpResetChan && item.channel == ChCounter
    |=> counter_total_q == '0 && counter_rep_q == '0)
    else $error("counter channel not cleared by reset op");

  a_delta_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && item.operation == OpReadDelta && item.channel == ChPin
    |=> pin_rep_q == pin_total_q)
    else $error("pin reported total not updated by delta read");

  a_pin_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && item.operation == OpPinSample
    |=> last_pin_q == {$past(item.pin_a), $past(item.pin_b)})
    else $error("last pin state not tracking sample");

endmodule

### rtl/dqec_out_stage.sv
// ----------------------------------------------------------------------------
// dqec_out_stage
// Result register; decouples the update stage from the downstream ready.
// ----------------------------------------------------------------------------
module dqec_out_stage
  import dqec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t result_i,
  output logic      slot_free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

### rtl/dual_quadrature_encoder_counter_core.sv
// ----------------------------------------------------------------------------
// dual_quadrature_encoder_counter_core
// Two-channel wheel encoder counter: one channel accumulates a sampled
// hardware counter, the other decodes A/B pins with an x4 table. One
// transaction is taken per clock while the result path does not stall; its
// result passes through the input register, the single-pass update (one
// table lookup and one 64-bit add) and the result register. A stalled result
// holds the update stage, and the input stalls once the input register is
// also full. Every transaction returns one result: the total of the channel
// that it updates or addresses and, for a delta read, the 32-bit change since
// the previous delta read.
// ----------------------------------------------------------------------------
module dual_quadrature_encoder_counter_core
  import dqec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  stage_t    stage;
  logic      advance;
  logic      slot_free;
  out_item_t result;

  dqec_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  dqec_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .slot_free_i (slot_free),
    .advance_o   (advance),
    .result_o    (result)
  );

  dqec_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dual_quadrature_encoder_counter_core. Directed
// transactions cover reset values, x4 pin decoding, counter wrap, delta reads,
// channel resets and spare opcodes. A run of full-size counter steps builds a
// large delta, and random traffic runs under four idle/stall mixes. A local
// encoder model predicts every result, and each output transaction is checked
// in order.
// ----------------------------------------------------------------------------
module tb
  import dqec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int          mismatches    = 0;

  // encoder model state
  logic [15:0] cnt_last;
  logic [63:0] cnt_total;
  logic [63:0] cnt_reported;
  logic [1:0]  pin_state;
  logic [63:0] pin_total;
  logic [63:0] pin_reported;

  out_item_t pending_readings[$];
  out_item_t expected_r;

  dual_quadrature_encoder_counter_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // gray position along 00 -> 01 -> 11 -> 10; one step forward counts +1
  function automatic logic [63:0] quad_move(logic [1:0] prev, logic [1:0] cur);
    logic [1:0] pos_diff;
    pos_diff = {cur[1], ^cur} - {prev[1], ^prev};
    case (pos_diff)
      2'd1:    return 64'd1;
      2'd3:    return '1;
      default: return '0;
    endcase
  endfunction

  function automatic out_item_t encoder_update(in_item_t txn);
    out_item_t   r;
    logic [15:0] step16;
    logic [63:0] diff;
    r = '0;
    case (txn.operation)
      OpPinSample: begin
        pin_total = pin_total + quad_move(pin_state, {txn.pin_a, txn.pin_b});
        pin_state = {txn.pin_a, txn.pin_b};
        r.total_count = pin_total;
      end
      OpCounterPoll: begin
        step16 = txn.counter_value - cnt_last;
        cnt_last = txn.counter_value;
        cnt_total = cnt_total + {{48{step16[15]}}, step16};
        r.total_count = cnt_total;
      end
      OpReadDelta: begin
        if (txn.channel == ChCounter) begin
          diff = cnt_total - cnt_reported;
          cnt_reported = cnt_total;
          r.total_count = cnt_total;
        end else begin
          diff = pin_total - pin_reported;
          pin_reported = pin_total;
          r.total_count = pin_total;
        end
        r.delta_count = diff[31:0];
      end
      OpResetChan: begin
        if (txn.channel == ChCounter) begin
          cnt_last = txn.counter_value;
          cnt_total = '0;
          cnt_reported = '0;
        end else begin
          pin_state = {txn.pin_a, txn.pin_b};
          pin_total = '0;
          pin_reported = '0;
        end
      end
      default: begin
        r.total_count = (txn.channel == ChCounter) ? cnt_total : pin_total;
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t make_txn(logic [2:0] op, logic ch, logic [1:0] pins,
                                        logic [15:0] cnt);
    in_item_t t;
    t.operation     = op;
    t.channel       = ch;
    t.pin_a         = pins[1];
    t.pin_b         = pins[0];
    t.counter_value = cnt;
    return t;
  endfunction

  task automatic send_txn(input in_item_t txn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= txn;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_readings.push_back(encoder_update(txn));
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected transaction: total_count %0d delta_count %0d",
               out_item.total_count, out_item.delta_count);
        mismatches++;
      end else begin
        expected_r = pending_readings.pop_front();
        if (out_item.total_count !== expected_r.total_count) begin
          $error("total_count: expected %0d, actual %0d",
                 expected_r.total_count, out_item.total_count);
          mismatches++;
        end
        if (out_item.delta_count !== expected_r.delta_count) begin
          $error("delta_count: expected %0d, actual %0d",
                 expected_r.delta_count, out_item.delta_count);
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic test_reset_values();
    send_txn(make_txn(OpReadTotal, ChCounter, 2'b00, 16'h0000));
    send_txn(make_txn(OpReadTotal, ChPin, 2'b11, 16'hFFFF));
    send_txn(make_txn(OpReadDelta, ChCounter, 2'b00, 16'h0000));
    send_txn(make_txn(OpReadDelta, ChPin, 2'b00, 16'h0000));
  endtask

  task automatic test_pin_decode();
    send_txn(make_txn(OpPinSample, ChPin, 2'b01, 16'h0000));
    send_txn(make_txn(OpPinSample, ChCounter, 2'b11, 16'hFFFF));  // channel field ignored
    send_txn(make_txn(OpPinSample, ChPin, 2'b10, 16'h0000));
    send_txn(make_txn(OpPinSample, ChPin, 2'b00, 16'h0000));
    send_txn(make_txn(OpPinSample, ChPin, 2'b10, 16'h0000));      // backward
    send_txn(make_txn(OpPinSample, ChPin, 2'b01, 16'h0000));      // both pins flip
    send_txn(make_txn(OpPinSample, ChPin, 2'b01, 16'h0000));      // no change
  endtask

  task automatic test_counter_wrap();
    send_txn(make_txn(OpCounterPoll, ChPin, 2'b11, 16'hFFFF));
    send_txn(make_txn(OpCounterPoll, ChCounter, 2'b00, 16'h7FFE));
    send_txn(make_txn(OpCounterPoll, ChCounter, 2'b00, 16'hFFFF));
    send_txn(make_txn(OpCounterPoll, ChCounter, 2'b00, 16'h7FFF));
  endtask

  task automatic test_read_delta();
    send_txn(make_txn(OpReadDelta, ChCounter, 2'b00, 16'h0000));
    send_txn(make_txn(OpReadDelta, ChPin, 2'b00, 16'h0000));
    send_txn(make_txn(OpReadDelta, ChCounter, 2'b00, 16'h0000));
  endtask

  task automatic test_channel_reset();
    send_txn(make_txn(OpResetChan, ChCounter, 2'b00, 16'h1234));
    send_txn(make_txn(OpCounterPoll, ChCounter, 2'b00, 16'h1235));
    send_txn(make_txn(OpResetChan, ChPin, 2'b11, 16'h0000));
    send_txn(make_txn(OpPinSample, ChPin, 2'b10, 16'h0000));
  endtask

  task automatic test_spare_ops();
    for (int op = OpSpareLo; op <= OpSpareHi; op++) begin
      send_txn(make_txn(3'(op), op[0], 2'b11, 16'hA5A5));
    end
  endtask

  // full-size positive steps back to back build a large delta
  task automatic test_delta_wrap();
    logic [15:0] cnt;
    send_idle_pct = 0;
    stall_pct     = 0;
    cnt = 16'h0000;
    send_txn(make_txn(OpResetChan, ChCounter, 2'b00, cnt));
    for (int i = 0; i < 32; i++) begin
      cnt = cnt + 16'h7FFF;
      send_txn(make_txn(OpCounterPoll, ChCounter, 2'b00, cnt));
    end
    send_txn(make_txn(OpReadDelta, ChCounter, 2'b00, 16'h0000));
    send_txn(make_txn(OpReadTotal, ChCounter, 2'b00, 16'h0000));
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall, int count);
    in_item_t txn;
    int       pick;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < count; i++) begin
      txn = in_item_t'($urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
        txn.operation = OpPinSample;
        if ($urandom_range(99) < 85) begin
          {txn.pin_a, txn.pin_b} = pin_state ^ ($urandom_range(1) ? 2'b01 : 2'b10);
        end
      end else if (pick < 65) begin
        txn.operation = OpCounterPoll;
        if ($urandom_range(99) < 70) begin
          txn.counter_value = cnt_last + 16'($urandom_range(400)) - 16'd200;
        end
      end else if (pick < 80) begin
        txn.operation = OpReadDelta;
      end else if (pick < 88) begin
        txn.operation = OpReadTotal;
      end else if (pick < 95) begin
        txn.operation = OpResetChan;
      end else begin
        txn.operation = 3'($urandom_range(OpSpareHi, OpSpareLo));
      end
      send_txn(txn);
    end
  endtask

  initial begin
    cnt_last     = '0;
    cnt_total    = '0;
    cnt_reported = '0;
    pin_state    = '0;
    pin_total    = '0;
    pin_reported = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_pin_decode();
    test_counter_wrap();
    test_read_delta();
    test_channel_reset();
    test_spare_ops();
    test_delta_wrap();
    test_random_traffic(0, 0, 250);
    test_random_traffic(74, 0, 250);
    test_random_traffic(0, 74, 250);
    test_random_traffic(12, 12, 250);

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
rtl/dqec_pkg.sv
rtl/dqec_in_stage.sv
rtl/dqec_update.sv
rtl/dqec_out_stage.sv
rtl/dual_quadrature_encoder_counter_core.sv
verif/tb.sv
